// ===== hdl/rrr_pkg.sv =====
// Shared types and constants for the rounded rectangle rasterizer.
package rrr_pkg;

  localparam int DIM_W      = 13;  // buffer and rectangle sizes
  localparam int POS_W      = 12;  // edge coordinates and radius
  localparam int CNT_W      = 13;  // walk counters
  localparam int IDX_W      = 24;  // frame buffer index
  localparam int COLOR_W    = 32;
  localparam int LIMIT_W    = 2 * DIM_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_LEFT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_TOP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_W        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_H        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_RADIUS = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOR    = 3'd7;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RECT1,
    PH_RECT2,
    PH_TL,
    PH_TR,
    PH_BL,
    PH_BR
  } phase_t;

  // One walk step as handed from the walker to the pixel stages
  typedef struct packed {
    logic             is_disc;
    logic             rect_keep;
    logic             rect_outside;
    logic [IDX_W-1:0] rect_idx;
    logic             done;
    logic             left;
    logic             top;
    logic [CNT_W-1:0] ic;
    logic [CNT_W-1:0] oc;
    logic [POS_W-1:0] r;
  } step_t;

  typedef struct packed {
    logic               write_valid;
    logic [IDX_W-1:0]   pixel_index;
    logic [COLOR_W-1:0] pixel_value;
    logic               blend_needed;
    logic               outside_buffer;
    logic               done_res;
  } result_t;

endpackage

// ===== hdl/rrr_walk.sv =====
// Walk sequencer: phase and counters, rectangle index and early stop.
module rrr_walk (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic                         restart,
  input  logic [rrr_pkg::DIM_W-1:0]    rect_w_s,
  input  logic [rrr_pkg::DIM_W-1:0]    rect_h_s,
  input  logic [rrr_pkg::DIM_W-1:0]    buffer_width_s,
  input  logic [rrr_pkg::POS_W-1:0]    rect_left,
  input  logic [rrr_pkg::POS_W-1:0]    rect_top,
  input  logic [rrr_pkg::POS_W-1:0]    corner_radius,
  input  logic [rrr_pkg::LIMIT_W-1:0]  limit,
  output rrr_pkg::step_t               step
);
  import rrr_pkg::*;

  localparam int RIDX_W = CNT_W + DIM_W + 2;

  typedef struct packed {
    logic             adv;
    logic [CNT_W-1:0] oc;
    logic [CNT_W-1:0] ic;
  } pos_t;

  // Skip rectangle positions that hold no candidate
  function automatic pos_t settle_rect(input logic [CNT_W-1:0] rows,
                                       input logic [CNT_W-1:0] cols,
                                       input logic [CNT_W-1:0] oc,
                                       input logic [CNT_W-1:0] ic);
    pos_t       res;
    logic [CNT_W:0] oc_inc;
    oc_inc = {1'b0, oc} + 1'b1;
    res.adv = 1'b0;
    res.oc  = oc;
    res.ic  = ic;
    if (rows == '0 || oc >= cols) begin
      res.adv = 1'b1;
    end else if (ic >= rows) begin
      if (oc_inc >= {1'b0, cols}) begin
        res.adv = 1'b1;
      end else begin
        res.oc = oc_inc[CNT_W-1:0];
        res.ic = '0;
      end
    end
    if (res.adv) begin
      res.oc = '0;
      res.ic = '0;
    end
    return res;
  endfunction

  phase_t           phase, phase_next;
  logic [CNT_W-1:0] outer_count, outer_count_next;
  logic [CNT_W-1:0] inner_count, inner_count_next;
  logic [POS_W-1:0] clamped_radius, clamped_radius_next;

  logic [POS_W-1:0] half_h, half_w, r_h, r_clamp, r_cur;
  logic             live;
  phase_t           ph0, ph_s;
  logic [CNT_W-1:0] oc0, ic0, oc_s, ic_s;
  logic [DIM_W-1:0] two_r, cols1, rows2;
  pos_t             set1, set2;
  logic [CNT_W-1:0] set2_oc, set2_ic;

  logic               in_rect1, in_rect, in_disc;
  logic [DIM_W-1:0]   x0, y0;
  logic [CNT_W-1:0]   rows_s;
  logic [CNT_W:0]     xc, yc, ic_inc, oc_inc;
  logic [RIDX_W-1:0]  row_base, idx_full;
  logic               stop, at_limit;
  logic               wrap_col, wrap_phase;

  // Radius clamp: half height, then half width
  assign half_h  = rect_h_s[DIM_W-1:1];
  assign half_w  = rect_w_s[DIM_W-1:1];
  assign r_h     = (corner_radius > half_h) ? half_h : corner_radius;
  assign r_clamp = (r_h > half_w) ? half_w : r_h;
  assign r_cur   = restart ? r_clamp : clamped_radius;
  assign live    = restart || (phase != PH_IDLE);

  assign ph0 = restart ? PH_RECT1 : phase;
  assign oc0 = restart ? '0 : outer_count;
  assign ic0 = restart ? '0 : inner_count;

  assign two_r = {r_cur, 1'b0};
  assign cols1 = (rect_w_s > two_r) ? rect_w_s - two_r : '0;
  assign rows2 = (rect_h_s > two_r) ? rect_h_s - two_r : '0;

  assign set2_oc = (ph0 == PH_RECT2) ? oc0 : '0;
  assign set2_ic = (ph0 == PH_RECT2) ? ic0 : '0;
  assign set1 = settle_rect(rect_h_s, cols1, oc0, ic0);
  assign set2 = settle_rect(rows2, rect_w_s, set2_oc, set2_ic);

  // Settled position
  always_comb begin
    ph_s = ph0;
    oc_s = oc0;
    ic_s = ic0;
    if (ph0 == PH_RECT1 && !set1.adv) begin
      oc_s = set1.oc;
      ic_s = set1.ic;
    end else if (ph0 == PH_RECT1 || ph0 == PH_RECT2) begin
      if (set2.adv) begin
        ph_s = PH_TL;
        oc_s = '0;
        ic_s = '0;
      end else begin
        ph_s = PH_RECT2;
        oc_s = set2.oc;
        ic_s = set2.ic;
      end
    end
  end

  // Rectangle candidate index and disc counter wraps
  assign in_rect1 = (ph_s == PH_RECT1);
  assign in_rect  = in_rect1 || (ph_s == PH_RECT2);
  assign in_disc  = live && !in_rect;
  assign x0       = in_rect1 ? DIM_W'(rect_left) + DIM_W'(r_cur) : DIM_W'(rect_left);
  assign y0       = in_rect1 ? DIM_W'(rect_top) : DIM_W'(rect_top) + DIM_W'(r_cur);
  assign rows_s   = in_rect1 ? rect_h_s : rows2;
  assign xc       = {1'b0, x0} + {1'b0, oc_s};
  assign yc       = {1'b0, y0} + {1'b0, ic_s};
  assign row_base = RIDX_W'(yc) * RIDX_W'(buffer_width_s);
  assign idx_full = row_base + RIDX_W'(xc);
  assign stop     = idx_full > RIDX_W'(limit);
  assign at_limit = idx_full == RIDX_W'(limit);

  assign ic_inc     = {1'b0, ic_s} + 1'b1;
  assign oc_inc     = {1'b0, oc_s} + 1'b1;
  assign wrap_col   = ic_inc > (CNT_W + 1)'(r_cur);
  assign wrap_phase = oc_inc > (CNT_W + 1)'(r_cur);

  // Next state
  always_comb begin
    phase_next          = phase;
    outer_count_next    = outer_count;
    inner_count_next    = inner_count;
    clamped_radius_next = clamped_radius;
    if (accept && live) begin
      clamped_radius_next = r_cur;
      phase_next          = ph_s;
      unique case (ph_s) inside
        PH_RECT1, PH_RECT2: begin
          if (stop) begin
            phase_next       = in_rect1 ? PH_RECT2 : PH_TL;
            outer_count_next = '0;
            inner_count_next = '0;
          end else if (ic_inc >= {1'b0, rows_s}) begin
            outer_count_next = oc_inc[CNT_W-1:0];
            inner_count_next = '0;
          end else begin
            outer_count_next = oc_s;
            inner_count_next = ic_inc[CNT_W-1:0];
          end
        end
        PH_TL, PH_TR, PH_BL, PH_BR: begin
          outer_count_next = oc_s;
          inner_count_next = ic_inc[CNT_W-1:0];
          if (wrap_col) begin
            inner_count_next = '0;
            outer_count_next = oc_inc[CNT_W-1:0];
            if (wrap_phase) begin
              outer_count_next = '0;
              unique case (ph_s)
                PH_TL:   phase_next = PH_TR;
                PH_TR:   phase_next = PH_BL;
                PH_BL:   phase_next = PH_BR;
                default: phase_next = PH_IDLE;
              endcase
            end
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // Step handed to the pixel stages
  always_comb begin
    step.is_disc      = in_disc;
    step.rect_keep    = live && in_rect && !stop && !at_limit;
    step.rect_outside = live && in_rect && (stop || at_limit);
    step.rect_idx     = idx_full[IDX_W-1:0];
    step.done         = in_disc && (ph_s == PH_BR) && wrap_col && wrap_phase;
    step.left         = (ph_s == PH_TL) || (ph_s == PH_BL);
    step.top          = (ph_s == PH_TL) || (ph_s == PH_TR);
    step.ic           = ic_s;
    step.oc           = oc_s;
    step.r            = r_cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      outer_count    <= '0;
      inner_count    <= '0;
      clamped_radius <= '0;
    end else begin
      phase          <= phase_next;
      outer_count    <= outer_count_next;
      inner_count    <= inner_count_next;
      clamped_radius <= clamped_radius_next;
    end
  end

endmodule

// ===== hdl/rrr_pixel.sv =====
// Pixel stages: disc test and disc index, then the result register.
module rrr_pixel (
  input  logic                          clk,
  input  logic                          en_mid,
  input  logic                          en_out,
  input  rrr_pkg::step_t                step,
  input  logic [rrr_pkg::DIM_W-1:0]     rect_w_s,
  input  logic [rrr_pkg::DIM_W-1:0]     rect_h_s,
  input  logic [rrr_pkg::DIM_W-1:0]     buffer_width_s,
  input  logic [rrr_pkg::POS_W-1:0]     rect_left,
  input  logic [rrr_pkg::POS_W-1:0]     rect_top,
  input  logic [rrr_pkg::LIMIT_W-1:0]   limit,
  input  logic [rrr_pkg::COLOR_W-1:0]   fill_color,
  output rrr_pkg::result_t              result
);
  import rrr_pkg::*;

  localparam int D_W   = CNT_W + 1;          // signed disc offset
  localparam int SQ_W  = 2 * POS_W + 1;      // one square
  localparam int XY_W  = DIM_W + 3;          // signed pixel coordinate
  localparam int YP_W  = XY_W + DIM_W + 1;   // signed row base
  localparam int P_W   = YP_W + 1;

  logic signed [D_W-1:0]    dx, dy;
  logic signed [2*D_W-1:0]  dx_prod, dy_prod;
  logic [2*POS_W-1:0]       r_prod;
  logic [XY_W-1:0]          base_x, base_y;
  logic signed [XY_W-1:0]   x_pos, y_pos;
  logic signed [YP_W-1:0]   y_prod;

  // Middle stage registers
  logic                     m_is_disc, m_rect_keep, m_rect_outside, m_done;
  logic [IDX_W-1:0]         m_rect_idx;
  logic [SQ_W-1:0]          m_dx_sq, m_dy_sq;
  logic [2*POS_W-1:0]       m_r_sq;
  logic signed [XY_W-1:0]   m_x;
  logic signed [YP_W-1:0]   m_y_prod;

  logic [SQ_W:0]            sum_sq;
  logic                     in_disc_area;
  logic signed [P_W-1:0]    p;
  logic                     p_neg, p_ge, p_out, keep, outside;
  logic [IDX_W-1:0]         idx;
  result_t                  result_next;

  assign dx = $signed({1'b0, step.ic}) - (step.left ? $signed(D_W'(step.r)) : '0);
  assign dy = $signed({1'b0, step.oc}) - (step.top  ? $signed(D_W'(step.r)) : '0);
  assign dx_prod = (2*D_W)'(dx) * (2*D_W)'(dx);
  assign dy_prod = (2*D_W)'(dy) * (2*D_W)'(dy);
  assign r_prod  = (2*POS_W)'(step.r) * (2*POS_W)'(step.r);

  // Corner centre minus radius on the near side, far edge minus radius otherwise
  assign base_x = step.left ? XY_W'(rect_left)
                : XY_W'(rect_left) + XY_W'(rect_w_s) - XY_W'(step.r) - XY_W'(1);
  assign base_y = step.top ? XY_W'(rect_top)
                : XY_W'(rect_top) + XY_W'(rect_h_s) - XY_W'(step.r) - XY_W'(1);
  assign x_pos  = $signed(base_x + XY_W'(step.ic));
  assign y_pos  = $signed(base_y + XY_W'(step.oc));
  assign y_prod = YP_W'(y_pos) * YP_W'($signed({1'b0, buffer_width_s}));

  always_ff @(posedge clk) begin
    if (en_mid) begin
      m_is_disc      <= step.is_disc;
      m_rect_keep    <= step.rect_keep;
      m_rect_outside <= step.rect_outside;
      m_rect_idx     <= step.rect_idx;
      m_done         <= step.done;
      m_dx_sq        <= dx_prod[SQ_W-1:0];
      m_dy_sq        <= dy_prod[SQ_W-1:0];
      m_r_sq         <= r_prod;
      m_x            <= x_pos;
      m_y_prod       <= y_prod;
    end
  end

  assign sum_sq       = {1'b0, m_dx_sq} + {1'b0, m_dy_sq};
  assign in_disc_area = sum_sq < (SQ_W + 1)'(m_r_sq);
  assign p            = P_W'(m_x) + P_W'(m_y_prod);
  assign p_neg        = p[P_W-1];
  assign p_ge         = !p_neg && (p[P_W-2:0] >= (P_W - 1)'(limit));
  assign p_out        = p_neg || p_ge;

  always_comb begin
    if (m_is_disc) begin
      keep    = in_disc_area && !p_out;
      outside = in_disc_area && p_out;
      idx     = p[IDX_W-1:0];
    end else begin
      keep    = m_rect_keep;
      outside = m_rect_outside;
      idx     = m_rect_idx;
    end
    result_next.write_valid    = keep;
    result_next.pixel_index    = keep ? idx : '0;
    result_next.pixel_value    = keep ? fill_color : '0;
    result_next.blend_needed   = keep && (fill_color[COLOR_W-1 -: 8] != ALPHA_OPAQUE);
    result_next.outside_buffer = outside;
    result_next.done_res       = m_done;
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      result <= result_next;
    end
  end

endmodule

// ===== hdl/rounded_rect_rasterizer_unit.sv =====
// Top level of the rounded rectangle rasterizer: registers, pipeline control.
//
//   channel   signals                              transfer when
//   -------   ----------------------------------   ---------------------------
//   config    cfg_we, cfg_index, cfg_data          cfg_we high
//   input     in_valid, in_ready, restart          in_valid and in_ready high
//   output    out_valid, out_ready, result fields  out_valid and out_ready high
//
// One tick is taken every cycle unless an output stall has filled the pipeline;
// its result passes the step, multiply and result registers in that order.
// The walk counters and phase advance in the transfer cycle, so the rectangle
// index multiply and limit compare set the walker's path.
// Synchronous reset clears the walk state and pipeline valids, sets a 640 by 480
// buffer, zeroes the other registers. An output stall holds every full stage.
module rounded_rect_rasterizer_unit #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rrr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rrr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              restart,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              write_valid,
  output logic [rrr_pkg::IDX_W-1:0]         pixel_index,
  output logic [rrr_pkg::COLOR_W-1:0]       pixel_value,
  output logic                              blend_needed,
  output logic                              outside_buffer,
  output logic                              done_res
);
  import rrr_pkg::*;

  localparam int unsigned DIM_MAXV = (1 << DIM_W) - 1;
  localparam logic [DIM_W-1:0] DIM_CAP =
    (MAX_DIM > DIM_MAXV) ? DIM_W'(DIM_MAXV) : DIM_W'(MAX_DIM);

  logic [DIM_W-1:0]   buffer_width, buffer_height, rect_w, rect_h;
  logic [POS_W-1:0]   rect_left, rect_top, corner_radius;
  logic [COLOR_W-1:0] fill_color;

  logic [DIM_W-1:0]   bw_s, bh_s, w_s, h_s;
  logic [LIMIT_W-1:0] limit;

  logic    en1, en_mid, en_out, accept;
  logic    s1_valid, s2_valid;
  step_t   step, s1_step;
  result_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_width  <= DIM_W'(640);
      buffer_height <= DIM_W'(480);
      rect_left     <= '0;
      rect_top      <= '0;
      rect_w        <= '0;
      rect_h        <= '0;
      corner_radius <= '0;
      fill_color    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BUFFER_WIDTH:  buffer_width  <= cfg_data[DIM_W-1:0];
        REG_BUFFER_HEIGHT: buffer_height <= cfg_data[DIM_W-1:0];
        REG_RECT_LEFT:     rect_left     <= cfg_data[POS_W-1:0];
        REG_RECT_TOP:      rect_top      <= cfg_data[POS_W-1:0];
        REG_RECT_W:        rect_w        <= cfg_data[DIM_W-1:0];
        REG_RECT_H:        rect_h        <= cfg_data[DIM_W-1:0];
        REG_CORNER_RADIUS: corner_radius <= cfg_data[POS_W-1:0];
        REG_FILL_COLOR:    fill_color    <= cfg_data[COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Saturate sizes to the largest supported dimension
  assign bw_s  = (buffer_width  > DIM_CAP) ? DIM_CAP : buffer_width;
  assign bh_s  = (buffer_height > DIM_CAP) ? DIM_CAP : buffer_height;
  assign w_s   = (rect_w > DIM_CAP) ? DIM_CAP : rect_w;
  assign h_s   = (rect_h > DIM_CAP) ? DIM_CAP : rect_h;
  assign limit = LIMIT_W'(bw_s) * LIMIT_W'(bh_s);

  // Advance a stage when the one after it is empty or moving
  assign en_out   = !out_valid || out_ready;
  assign en_mid   = !s2_valid || en_out;
  assign en1      = !s1_valid || en_mid;
  assign in_ready = en1;
  assign accept   = in_valid && in_ready;

  rrr_walk u_walk (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .restart        (restart),
    .rect_w_s       (w_s),
    .rect_h_s       (h_s),
    .buffer_width_s (bw_s),
    .rect_left      (rect_left),
    .rect_top       (rect_top),
    .corner_radius  (corner_radius),
    .limit          (limit),
    .step           (step)
  );

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_step <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid <= in_valid;
      end
      if (en_mid) begin
        s2_valid <= s1_valid;
      end
      if (en_out) begin
        out_valid <= s2_valid;
      end
    end
  end

  rrr_pixel u_pixel (
    .clk            (clk),
    .en_mid         (en_mid),
    .en_out         (en_out),
    .step           (s1_step),
    .rect_w_s       (w_s),
    .rect_h_s       (h_s),
    .buffer_width_s (bw_s),
    .rect_left      (rect_left),
    .rect_top       (rect_top),
    .limit          (limit),
    .fill_color     (fill_color),
    .result         (result)
  );

  assign write_valid    = result.write_valid;
  assign pixel_index    = result.pixel_index;
  assign pixel_value    = result.pixel_value;
  assign blend_needed   = result.blend_needed;
  assign outside_buffer = result.outside_buffer;
  assign done_res       = result.done_res;

endmodule
